@@ src/gna_pkg.sv @@
`timescale 1ns / 1ps

package gna_pkg;

    // generator and transform constants
    localparam logic [31:0] LCG_MUL_LO  = 32'hDEEC_E66D;
    localparam logic [15:0] LCG_MUL_HI  = 16'd5;
    localparam logic [47:0] LCG_ADD     = 48'hB;
    localparam logic [15:0] SEED_LOW    = 16'h330E;
    localparam logic [31:0] TWO_LN2_Q27 = 32'd186065279;
    localparam logic [31:0] HALF_PI_LO  = 32'd2451551556;
    localparam logic [31:0] GAIN_Q30    = 32'd652032874;
    localparam logic [23:0] STD_RESET   = 24'd32768;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [4:0] LOG_LAST  = 5'd29;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] ROT_LAST  = 5'd29;
    localparam logic [1:0] PAIR_LAST = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STD_DEV = 2'd0,
        REG_MEAN    = 2'd1,
        REG_SEED    = 2'd2
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DRAW_LO, S_DRAW_HI, S_NORM_INIT, S_NORM, S_LOG_INIT, S_LOG,
        S_D, S_V_LO, S_V_HI, S_SQRT, S_ANG, S_GAIN, S_ROT, S_ROUND, S_CACHE,
        S_SCALE, S_SUM
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DRAW_LO, OP_DRAW_HI, OP_NORM_INIT, OP_NORM,
        OP_LOG_INIT, OP_LOG, OP_D, OP_V_LO, OP_V_HI, OP_SQRT, OP_ANG, OP_GAIN,
        OP_ROT, OP_ROUND, OP_USE_CACHE, OP_SCALE, OP_SUM
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       second;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic pair_phase;
        logic x1_zero;
        logic norm_done;
        logic out_free;
    } t_status;

    // atan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

@@ src/gaussian_noise_adder_core.sv @@
`timescale 1ns / 1ps
// channel  | direction | handshake                   | payload
// input    | in        | i_in_valid / o_in_stall     | i_in_activity
// output   | out       | o_out_valid / i_out_stall   | o_out_activity
// config   | in        | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// a request that starts a new pair of deviates draws, normalises and takes
// the log (30 squarings on the shared 32x32 multiplier), then the 32-step
// root and the 30-step rotation; it takes longer when a zero first draw is
// drawn again or the first draw has many leading zeros; the request that
// uses the stored deviate goes straight to scaling
// reset (synchronous, active low) restores the register defaults and seed 0
// one request is in work at a time; the next is taken while a result waits
// in the output register, and a stalled result holds the datapath at its end

module gaussian_noise_adder_core #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_activity,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_activity,
    // register writes: std_dev, mean_offset, seed_value
    input  logic                                i_cfg_we,
    input  logic [gna_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gna_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gna_pkg::*;

    // command from the sequencer, status back from the datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: draws, log, root, rotation, scaling, hand-off
    gna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // box-muller datapath around a shared 32x32 multiplier, a separate scaling multiplier, plus output register
    gna_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_activity  (i_in_activity),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_activity (o_out_activity)
    );

endmodule

@@ src/gna_ctrl.sv @@
`timescale 1ns / 1ps

module gna_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output gna_pkg::t_cmd     o_cmd,
    input  gna_pkg::t_status  i_status
);
    import gna_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_tries, n_tries;
    logic       r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tries  <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_tries  <= n_tries;
            r_second <= n_second;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_tries      = r_tries;
        n_second     = r_second;
        o_cmd.op     = OP_NONE;
        o_cmd.second = r_second;
        o_cmd.step   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_tries  = '0;
                    n_second = 1'b0;
                    n_state  = i_status.pair_phase ? S_CACHE : S_DRAW_LO;
                end
            end
            S_DRAW_LO: begin
                o_cmd.op = OP_DRAW_LO;
                n_state  = S_DRAW_HI;
            end
            S_DRAW_HI: begin
                o_cmd.op = OP_DRAW_HI;
                if (!r_second) begin
                    n_second = 1'b1;
                    n_state  = S_DRAW_LO;
                end else begin
                    n_second = 1'b0;
                    n_tries  = r_tries + 2'd1;
                    // zero first draw: draw the pair again, up to four pairs
                    if (i_status.x1_zero && r_tries != PAIR_LAST) n_state = S_DRAW_LO;
                    else n_state = S_NORM_INIT;
                end
            end
            S_NORM_INIT: begin
                o_cmd.op = OP_NORM_INIT;
                n_state  = S_NORM;
            end
            S_NORM: begin
                o_cmd.op = OP_NORM;
                if (i_status.norm_done) n_state = S_LOG_INIT;
            end
            S_LOG_INIT: begin
                o_cmd.op = OP_LOG_INIT;
                n_cnt    = '0;
                n_state  = S_LOG;
            end
            S_LOG: begin
                o_cmd.op = OP_LOG;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == LOG_LAST) n_state = S_D;
            end
            S_D: begin
                o_cmd.op = OP_D;
                n_state  = S_V_LO;
            end
            S_V_LO: begin
                o_cmd.op = OP_V_LO;
                n_state  = S_V_HI;
            end
            S_V_HI: begin
                o_cmd.op = OP_V_HI;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == SQRT_LAST) n_state = S_ANG;
            end
            S_ANG: begin
                o_cmd.op = OP_ANG;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.op = OP_GAIN;
                n_cnt    = '0;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == ROT_LAST) n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = S_SCALE;
            end
            S_CACHE: begin
                o_cmd.op = OP_USE_CACHE;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ src/gna_dp.sv @@
`timescale 1ns / 1ps

module gna_dp #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gna_pkg::t_cmd                       i_cmd,
    output gna_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [gna_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gna_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_activity,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_activity
);
    import gna_pkg::*;

    localparam int SUM_W = ((SAMPLE_WIDTH > 34) ? SAMPLE_WIDTH : 34) + 1;

    // configuration and generator state
    logic [23:0]        r_std;
    logic signed [31:0] r_mean;
    logic [47:0]        r_lcg;
    logic signed [23:0] r_cache;
    logic               r_phase;
    logic               r_out_valid;

    // working registers
    logic [63:0]        r_prod;
    logic [47:0]        r_x1, r_x2, r_norm;
    logic [5:0]         r_nz;
    logic [31:0]        r_m;
    logic [29:0]        r_f;
    logic [35:0]        r_d;
    logic [63:0]        r_rad, r_res, r_bit;
    logic [1:0]         r_q;
    logic signed [32:0] r_a;
    logic signed [33:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [48:0] r_nprod;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_DRAW_LO: begin mul_a = r_lcg[31:0];             mul_b = LCG_MUL_LO;  end
            OP_DRAW_HI: begin mul_a = {16'b0, r_lcg[47:32]};   mul_b = LCG_MUL_LO;  end
            OP_LOG:     begin mul_a = r_m;                     mul_b = r_m;         end
            OP_V_LO:    begin mul_a = r_d[31:0];               mul_b = TWO_LN2_Q27; end
            OP_V_HI:    begin mul_a = {28'b0, r_d[35:32]};     mul_b = TWO_LN2_Q27; end
            OP_ANG:     begin mul_a = {2'b0, r_x2[45:16]};     mul_b = HALF_PI_LO;  end
            OP_GAIN:    begin mul_a = r_res[31:0];             mul_b = GAIN_Q30;    end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // generator step: low product from the previous cycle, upper 16 bits here
    logic [15:0] lcg_hi16;
    logic [47:0] n_lcg;
    assign lcg_hi16 = r_prod[47:32] + mul_p[15:0] + 16'(r_lcg[15:0] * LCG_MUL_HI);
    assign n_lcg    = {lcg_hi16, r_prod[31:0]} + LCG_ADD;

    // squaring step of the log
    logic [32:0] sq_t;
    logic [31:0] n_m;
    assign sq_t = mul_p[63:31];
    assign n_m  = sq_t[32] ? sq_t[32:1] : sq_t[31:0];

    // -2 ln u1 and radicand
    logic [63:0] v_full, n_rad;
    assign v_full = r_prod + {mul_p[31:0], 32'b0};
    assign n_rad  = {5'b0, v_full[63:27], 22'b0};

    // root step
    logic [63:0] trial;
    logic        ge;
    assign trial = r_res + r_bit;
    assign ge    = (r_rad >= trial);

    // angle inside the quadrant
    logic [31:0] ang_sum;
    assign ang_sum = {2'b0, r_x2[45:16]} + mul_p[63:32];

    // rotation step
    logic signed [33:0] sx, sy;
    logic signed [32:0] at;
    assign sx = r_x >>> i_cmd.step;
    assign sy = r_y >>> i_cmd.step;
    assign at = $signed({3'b0, atan_q30(i_cmd.step)});

    // quadrant map and rounding to Q8.16
    logic signed [33:0] qc, qs, qc_r, qs_r;
    always_comb begin
        case (r_q)
            2'd0:    begin qc = r_x;  qs = r_y;  end
            2'd1:    begin qc = -r_y; qs = r_x;  end
            2'd2:    begin qc = -r_x; qs = -r_y; end
            default: begin qc = r_y;  qs = -r_x; end
        endcase
    end
    assign qc_r = qc + 34'sd512;
    assign qs_r = qs + 34'sd512;

    // noise scaling, offset and saturation
    logic signed [24:0]      std_s;
    logic signed [48:0]      noise_r;
    logic signed [32:0]      noise;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-SAMPLE_WIDTH:0] sum_top;
    logic                    ovf;
    logic signed [SAMPLE_WIDTH-1:0] n_out;
    logic                    out_free;

    assign std_s   = $signed({1'b0, r_std});
    assign noise_r = r_nprod + 49'sd32768;
    assign noise   = noise_r[48:16];
    assign sum     = SUM_W'(r_sample) + SUM_W'(noise) + SUM_W'(r_mean);
    assign sum_top = sum[SUM_W-1:SAMPLE_WIDTH-1];
    assign ovf     = !((&sum_top) || !(|sum_top));
    assign n_out   = ovf ? (sum[SUM_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                         : sum[SAMPLE_WIDTH-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.pair_phase = r_phase;
    assign o_status.x1_zero    = (r_x1 == '0);
    assign o_status.norm_done  = r_norm[47];
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_out_activity = r_out;

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std       <= STD_RESET;
            r_mean      <= '0;
            r_lcg       <= {32'b0, SEED_LOW};
            r_cache     <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_STD_DEV: r_std  <= i_cfg_data[23:0];
                    REG_MEAN:    r_mean <= $signed(i_cfg_data);
                    REG_SEED:    r_lcg  <= {i_cfg_data, SEED_LOW};
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_DRAW_HI) r_lcg <= n_lcg;
            if (i_cmd.op == OP_ROUND) begin
                r_cache <= qs_r[33:10];
                r_phase <= 1'b1;
            end
            if (i_cmd.op == OP_USE_CACHE) r_phase <= 1'b0;
            if (i_cmd.op == OP_SUM && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD:    r_sample <= i_in_activity;
            OP_DRAW_LO: r_prod <= mul_p;
            OP_DRAW_HI: begin
                if (i_cmd.second) r_x2 <= n_lcg;
                else r_x1 <= n_lcg;
            end
            OP_NORM_INIT: begin
                r_norm <= (r_x1 == '0) ? 48'd1 : r_x1;
                r_nz   <= '0;
            end
            OP_NORM: begin
                if (!r_norm[47]) begin
                    if (r_norm[47:40] == '0) begin
                        r_norm <= {r_norm[39:0], 8'b0};
                        r_nz   <= r_nz + 6'd8;
                    end else begin
                        r_norm <= {r_norm[46:0], 1'b0};
                        r_nz   <= r_nz + 6'd1;
                    end
                end
            end
            OP_LOG_INIT: begin
                r_m <= r_norm[47:16];
                r_f <= '0;
            end
            OP_LOG: begin
                r_m <= n_m;
                r_f <= {r_f[28:0], sq_t[32]};
            end
            OP_D:    r_d <= {r_nz + 6'd1, 30'b0} - {6'b0, r_f};
            OP_V_LO: r_prod <= mul_p;
            OP_V_HI: begin
                r_rad <= n_rad;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT: begin
                if (ge) begin
                    r_rad <= r_rad - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_ANG: begin
                r_a <= $signed({1'b0, ang_sum});
                r_q <= r_x2[47:46];
            end
            OP_GAIN: begin
                r_x <= $signed(mul_p[63:30]);
                r_y <= '0;
            end
            OP_ROT: begin
                if (!r_a[32]) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_a <= r_a - at;
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_a <= r_a + at;
                end
            end
            OP_ROUND:     r_z <= qc_r[33:10];
            OP_USE_CACHE: r_z <= r_cache;
            OP_SCALE:     r_nprod <= r_z * std_s;
            OP_SUM: begin
                if (out_free) r_out <= n_out;
            end
            default: ;
        endcase
    end

endmodule

@@ src/gna_chk.sv @@
`timescale 1ns / 1ps

module gna_chk #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_activity,
    input logic                           o_out_valid,
    input logic                           i_out_stall
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_activity))
        else $error("stalled result changed");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a taken request keeps the input side busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // a new result only comes out of a request in work
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without request in work");

endmodule

bind gaussian_noise_adder_core gna_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gna_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_activity (o_out_activity),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall)
);

@@ tb/gaussian_noise_adder_core_tb.sv @@
`timescale 1ns / 1ps

module gaussian_noise_adder_core_tb;
    import gna_pkg::*;

    localparam int W = 32;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic signed [W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
    localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} t_row;
    typedef struct {
        t_row              kind;
        logic [1:0]        idx;
        logic [31:0]       data;
        logic signed [W-1:0] sample;
        bit                typed;
        logic signed [W-1:0] want;
    } t_stim;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic signed [W-1:0] i_in_activity = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [W-1:0] o_out_activity;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gaussian_noise_adder_core #(.SAMPLE_WIDTH(W)) uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the block's registers and generator state
    logic [23:0] p_std;
    logic signed [31:0] p_mean;
    logic [47:0] p_lcg;
    logic signed [31:0] p_cached;
    bit p_second;

    logic signed [W-1:0] want_q[$];
    int mismatches = 0;
    int strays = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int cycles = 0;
    bit idle_on = 1'b1;
    int hold_asked = 0;

    longint atan_tab[30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    function automatic logic [47:0] lcg_advance();
        logic [95:0] prod;
        prod = p_lcg * LCG_MULT + LCG_ADD;
        p_lcg = prod[47:0];
        return p_lcg;
    endfunction

    // Box-Muller pair in fixed point: z0 returned, z1 stored for next request
    function automatic logic signed [31:0] draw_pair();
        logic [47:0] x1, x2;
        longint unsigned m, f, d, v, r, w, rem, bitv;
        longint x, y, a, nx, c, s;
        int e, tries;
        tries = 0;
        do begin
            x1 = lcg_advance();
            x2 = lcg_advance();
            tries++;
        end while (x1 == 0 && tries < 4);
        if (x1 == 0) x1 = 48'd1;
        e = 0;
        for (int i = 0; i < 48; i++) if (x1[i]) e = i;
        m = (e >= 31) ? (longint'(x1) >> (e - 31)) : (longint'(x1) << (31 - e));
        f = 0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                f = f | 1;
            end
        end
        d = (longint'(48 - e) << 30) - f;
        v = (d * TWO_LN2_Q27) >> 27;
        // integer square root of v << 22
        rem = v << 22;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= r + bitv) begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        w = x2[45:16];
        a = longint'((w * HALF_PI_Q32) >> 32);
        x = longint'((r * GAIN_Q30) >> 30);
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a = a - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a = a + atan_tab[i];
            end
            x = nx;
        end
        case (x2[47:46])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        p_cached = 32'((s + 512) >>> 10);
        return 32'((c + 512) >>> 10);
    endfunction

    function automatic logic signed [W-1:0] noisy_sample(logic signed [W-1:0] smp);
        longint z, noise, sum;
        if (!p_second) begin
            z = draw_pair();
            p_second = 1'b1;
        end else begin
            z = p_cached;
            p_second = 1'b0;
        end
        noise = ((z * longint'({1'b0, p_std}) + 32768) >>> 16) + longint'(p_mean);
        sum = longint'(smp) + noise;
        if (sum > longint'(S_MAX)) sum = S_MAX;
        if (sum < longint'(S_MIN)) sum = S_MIN;
        return sum[W-1:0];
    endfunction

    function automatic void shadow_write(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_STD_DEV: p_std = data[23:0];
            REG_MEAN:    p_mean = data;
            REG_SEED:    p_lcg = {data, SEED_LOW};
            default: ;
        endcase
    endfunction

    // register write, only once every pending result has come back
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_write(idx, data);
    endtask

    // offer one request, predict its result once it is taken
    task automatic send_request(logic signed [W-1:0] smp, bit typed,
                                logic signed [W-1:0] want);
        logic signed [W-1:0] predicted;
        while (idle_on && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            i_in_activity <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_activity <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = noisy_sample(smp);
        want_q.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    function automatic logic signed [W-1:0] random_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            2: return $signed(32'($urandom_range(131071))) - 32'sd65536;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall, plus a long hold-off when asked
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int hold_done = 0;
        if (hold_done < hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 37);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (want_q.size() == 0) begin
                strays++;
                if (strays <= 10) $display("unexpected result %h", o_out_activity);
            end else begin
                logic signed [W-1:0] w;
                w = want_q.pop_front();
                if (o_out_activity !== w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected %h, got %h",
                                 results_seen, w, o_out_activity);
                end
            end
        end
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    t_stim table_rows[$];

    task automatic add_sample(logic signed [W-1:0] smp, bit typed = 0,
                              logic signed [W-1:0] want = '0);
        table_rows.push_back('{ROW_SAMPLE, 2'd0, 32'd0, smp, typed, want});
    endtask

    task automatic add_write(logic [1:0] idx, logic [31:0] data);
        table_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
    endtask

    initial begin
        int n;
        p_std = STD_RESET;
        p_mean = '0;
        p_lcg = {32'd0, SEED_LOW};
        p_cached = '0;
        p_second = 1'b0;

        // directed table
        add_sample(32'sd0);                         // reset defaults, seed 0
        add_sample(32'sh0001_0000);
        add_sample(S_MAX);
        add_write(REG_STD_DEV, 32'd0);              // no noise: result is the sample
        add_sample(32'sd0, 1, 32'sd0);
        add_sample(S_MAX, 1, S_MAX);
        add_sample(S_MIN, 1, S_MIN);
        add_sample(-32'sd1, 1, -32'sd1);
        add_write(REG_MEAN, 32'h7FFF_FFFF);         // saturation high
        add_sample(S_MAX, 1, S_MAX);
        add_sample(32'sd0, 1, S_MAX);
        add_write(REG_MEAN, 32'h8000_0000);         // saturation low
        add_sample(S_MIN, 1, S_MIN);
        add_sample(-32'sd1, 1, S_MIN);
        add_write(REG_MEAN, 32'd0);
        add_write(REG_STD_DEV, 32'h00FF_FFFF);      // widest noise
        add_sample(32'sd12345);
        add_write(REG_SEED, 32'hFFFF_FFFF);         // seed reload between pairs, no z1 stored
        add_sample(32'sd0);
        add_write(REG_STD_DEV, 32'h0001_0000);      // stored z1 scaled by new std_dev
        add_sample(32'sd0);
        add_sample(32'sd0);
        add_write(REG_UNUSED, 32'hFFFF_FFFF);       // unknown index is ignored
        add_sample(32'sd0);
        add_sample(32'sd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            if (table_rows[k].kind == ROW_WRITE)
                write_reg(table_rows[k].idx, table_rows[k].data);
            else
                send_request(table_rows[k].sample, table_rows[k].typed, table_rows[k].want);
        end

        // random part, with register changes between phases
        n = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_SEED, $urandom);
                    write_reg(REG_STD_DEV, 32'h0001_0000);
                    write_reg(REG_MEAN, 32'd0);
                end
                1: begin
                    write_reg(REG_STD_DEV, 32'h00FF_FFFF);
                    write_reg(REG_MEAN, 32'h7FFF_FFFF);
                end
                2: begin
                    write_reg(REG_STD_DEV, 32'd0);
                    write_reg(REG_MEAN, 32'h8000_0000);
                    write_reg(REG_SEED, 32'd0);
                end
                default: begin
                    write_reg(REG_STD_DEV, $urandom_range(24'hFF_FFFF));
                    write_reg(REG_MEAN, $urandom);
                    write_reg(REG_SEED, $urandom);
                end
            endcase
            for (int j = 0; j < 275; j++) begin
                idle_on = !(n >= 300 && n < 550);   // a long run with no idling
                if (n == 700) hold_asked++;         // receiver holds off, input backs up
                send_request(random_sample(), 1'b0, '0);
                n++;
                if ($urandom_range(99) < 3) begin
                    // occasional mid-stream write, including mid-pair
                    write_reg(2'($urandom_range(3)), $urandom);
                end
            end
        end
        i_in_valid <= 1'b0;
        idle_on = 1'b1;

        while (want_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked over several register settings",
                 requests_sent, results_seen);
        $display("%0d mismatches, %0d unexpected, %0d missing",
                 mismatches, strays, want_q.size());
        if (mismatches == 0 && strays == 0 && want_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
